FILE: hw/rtl/hlli_pkg.sv
// ----------------------------------------------------------------------------
// hlli_pkg
// Shared types, widths and arithmetic helpers for the hex line LED walker.
// ----------------------------------------------------------------------------
package hlli_pkg;

    localparam int COORD_W      = 5;
    localparam int COLOR_W      = 24;
    localparam int IDX_W        = 8;
    localparam int VAL_W        = 8;
    localparam int DIST_W       = 6;
    localparam int RING_CNT_DEF = 8;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        val_t               aq;
        val_t               ar;
        val_t               as_c;
        val_t               dq;
        val_t               dr;
        val_t               ds;
        logic [DIST_W-1:0]  span;
        logic [COLOR_W-1:0] color;
    } line_t;

    typedef struct packed {
        val_t               q;
        val_t               r;
        logic [COLOR_W-1:0] color;
        logic               last;
    } point_t;

    typedef struct packed {
        val_t val;
        val_t err;
    } rnd_t;

    typedef struct packed {
        val_t k;
        val_t rem;
    } acc_t;

    function automatic val_t sat_coord(input logic signed [COORD_W-1:0] c);
        val_t v;
        v = VAL_W'(c);
        if (v < -val_t'(15))
        begin
            v = -val_t'(15);
        end
        return v;
    endfunction

    function automatic val_t abs_val(input val_t v);
        return (v < 0) ? -v : v;
    endfunction

    // n = k*D + rem, 0 <= rem < D; round half away from zero
    function automatic rnd_t round_axis(input val_t k, input val_t rem,
                                        input logic [DIST_W-1:0] span);
        rnd_t o;
        val_t d;
        logic up;
        d = VAL_W'(span);
        if (k < 0)
        begin
            up = (2 * rem) > d;
        end
        else
        begin
            up = (2 * rem) >= d;
        end
        up    = up && (span != '0);
        o.val = k + VAL_W'(up);
        o.err = up ? (d - rem) : rem;
        return o;
    endfunction

    function automatic acc_t step_axis(input val_t k, input val_t rem, input val_t dc,
                                       input logic [DIST_W-1:0] span);
        acc_t o;
        val_t d;
        d     = VAL_W'(span);
        o.k   = k;
        o.rem = rem + dc;
        if (dc >= 0 && o.rem >= d)
        begin
            o.rem = o.rem - d;
            o.k   = k + val_t'(1);
        end
        else if (o.rem < 0)
        begin
            o.rem = o.rem + d;
            o.k   = k - val_t'(1);
        end
        return o;
    endfunction

endpackage

FILE: hw/rtl/hex_line_led_indices.sv
// ----------------------------------------------------------------------------
// hex_line_led_indices
// Hex line walker producing one LED index item per point of a line.
// ----------------------------------------------------------------------------
// A line item of cube distance D gives D+1 result items, one per cycle while
// pop keeps up; after the last point of a line the walker loads the next line
// from its two-entry queue before it steps again, so lines do not overlap.
// Each point comes from incremental quotient/remainder counters, so no divider
// is used; the LED mapping feeds one register stage that holds the result item.
module hex_line_led_indices
#(
    parameter int RING_CNT = hlli_pkg::RING_CNT_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [hlli_pkg::COORD_W-1:0]  start_q,
    input  logic signed [hlli_pkg::COORD_W-1:0]  start_r,
    input  logic signed [hlli_pkg::COORD_W-1:0]  end_q,
    input  logic signed [hlli_pkg::COORD_W-1:0]  end_r,
    input  logic        [hlli_pkg::COLOR_W-1:0]  pixel_color,
    output logic                                 empty,
    input  logic                                 pop,
    output logic        [hlli_pkg::IDX_W-1:0]    led_index,
    output logic                                 on_panel,
    output logic signed [hlli_pkg::COORD_W-1:0]  point_q,
    output logic signed [hlli_pkg::COORD_W-1:0]  point_r,
    output logic        [hlli_pkg::COLOR_W-1:0]  out_color,
    output logic                                 last_point
);
    import hlli_pkg::*;

    logic   q_wr, q_rd, q_nempty, pt_valid, pt_take;
    line_t  q_wdata, q_rdata;
    point_t pt;

    hlli_front u_front
    (
        .push        (push),
        .q_full      (full),
        .start_q     (start_q),
        .start_r     (start_r),
        .end_q       (end_q),
        .end_r       (end_r),
        .pixel_color (pixel_color),
        .q_wr        (q_wr),
        .q_wdata     (q_wdata)
    );

    hlli_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wdata  (q_wdata),
        .rd     (q_rd),
        .rdata  (q_rdata),
        .nempty (q_nempty),
        .full   (full)
    );

    hlli_walk u_walk
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_nempty (q_nempty),
        .q_rdata  (q_rdata),
        .q_rd     (q_rd),
        .pt_take  (pt_take),
        .pt_valid (pt_valid),
        .pt       (pt)
    );

    hlli_map #(.RING_CNT(RING_CNT)) u_map
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pt_valid   (pt_valid),
        .pt         (pt),
        .pt_take    (pt_take),
        .pop        (pop),
        .empty      (empty),
        .led_index  (led_index),
        .on_panel   (on_panel),
        .point_q    (point_q),
        .point_r    (point_r),
        .out_color  (out_color),
        .last_point (last_point)
    );

endmodule

FILE: hw/rtl/hlli_front.sv
// ----------------------------------------------------------------------------
// hlli_front
// Accepts line items, clamps coordinates, and computes deltas and distance.
// ----------------------------------------------------------------------------
module hlli_front
(
    input  logic                                 push,
    input  logic                                 q_full,
    input  logic signed [hlli_pkg::COORD_W-1:0]  start_q,
    input  logic signed [hlli_pkg::COORD_W-1:0]  start_r,
    input  logic signed [hlli_pkg::COORD_W-1:0]  end_q,
    input  logic signed [hlli_pkg::COORD_W-1:0]  end_r,
    input  logic        [hlli_pkg::COLOR_W-1:0]  pixel_color,
    output logic                                 q_wr,
    output hlli_pkg::line_t                      q_wdata
);
    import hlli_pkg::*;

    val_t aq, ar, bq, br, as_c, bs_c, dq, dr, ds;
    logic [VAL_W:0] sum;

    always_comb
    begin
        aq   = sat_coord(start_q);
        ar   = sat_coord(start_r);
        bq   = sat_coord(end_q);
        br   = sat_coord(end_r);
        as_c = -aq - ar;
        bs_c = -bq - br;
        dq   = bq - aq;
        dr   = br - ar;
        ds   = bs_c - as_c;
        sum  = (VAL_W+1)'(abs_val(dq)) + (VAL_W+1)'(abs_val(dr)) + (VAL_W+1)'(abs_val(ds));
        q_wdata.aq    = aq;
        q_wdata.ar    = ar;
        q_wdata.as_c  = as_c;
        q_wdata.dq    = dq;
        q_wdata.dr    = dr;
        q_wdata.ds    = ds;
        q_wdata.span  = sum[DIST_W:1];
        q_wdata.color = pixel_color;
    end

    assign q_wr = push && !q_full;

endmodule

FILE: hw/rtl/hlli_queue.sv
// ----------------------------------------------------------------------------
// hlli_queue
// Two-entry queue of decoded lines between front and walker.
// ----------------------------------------------------------------------------
module hlli_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  hlli_pkg::line_t wdata,
    input  logic            rd,
    output hlli_pkg::line_t rdata,
    output logic            nempty,
    output logic            full
);
    import hlli_pkg::*;

    line_t      mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;

    assign nempty = cnt_reg != 2'd0;
    assign full   = cnt_reg == 2'd2;
    assign rdata  = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(wr) - 2'(rd);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

endmodule

FILE: hw/rtl/hlli_walk.sv
// ----------------------------------------------------------------------------
// hlli_walk
// Walks a line point by point with incremental rationals and cube rounding.
// ----------------------------------------------------------------------------
module hlli_walk
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_nempty,
    input  hlli_pkg::line_t q_rdata,
    output logic            q_rd,
    input  logic            pt_take,
    output logic            pt_valid,
    output hlli_pkg::point_t pt
);
    import hlli_pkg::*;

    logic               busy_reg;
    logic [DIST_W-1:0]  i_reg, d_reg;
    val_t               kq_reg, kr_reg, ks_reg;
    val_t               remq_reg, remr_reg, rems_reg;
    val_t               dcq_reg, dcr_reg, dcs_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               pt_valid_reg;
    point_t             pt_reg, pt_next;
    logic               step;
    rnd_t               rq, rr, rs;
    acc_t               nq, nr, ns;

    assign q_rd     = !busy_reg && q_nempty;
    assign step     = busy_reg && (!pt_valid_reg || pt_take);
    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

    always_comb
    begin
        rq = round_axis(kq_reg, remq_reg, d_reg);
        rr = round_axis(kr_reg, remr_reg, d_reg);
        rs = round_axis(ks_reg, rems_reg, d_reg);
        nq = step_axis(kq_reg, remq_reg, dcq_reg, d_reg);
        nr = step_axis(kr_reg, remr_reg, dcr_reg, d_reg);
        ns = step_axis(ks_reg, rems_reg, dcs_reg, d_reg);
        pt_next.q     = rq.val;
        pt_next.r     = rr.val;
        pt_next.color = color_reg;
        pt_next.last  = i_reg == d_reg;
        if (rq.err > rr.err && rq.err > rs.err)
        begin
            pt_next.q = -rr.val - rs.val;
        end
        else if (rr.err > rs.err)
        begin
            pt_next.r = -rq.val - rs.val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            i_reg     <= '0;
            d_reg     <= q_rdata.span;
            kq_reg    <= q_rdata.aq;
            kr_reg    <= q_rdata.ar;
            ks_reg    <= q_rdata.as_c;
            remq_reg  <= '0;
            remr_reg  <= '0;
            rems_reg  <= '0;
            dcq_reg   <= q_rdata.dq;
            dcr_reg   <= q_rdata.dr;
            dcs_reg   <= q_rdata.ds;
            color_reg <= q_rdata.color;
        end
        else if (step)
        begin
            i_reg    <= i_reg + DIST_W'(1);
            kq_reg   <= nq.k;
            kr_reg   <= nr.k;
            ks_reg   <= ns.k;
            remq_reg <= nq.rem;
            remr_reg <= nr.rem;
            rems_reg <= ns.rem;
        end
        if (step)
        begin
            pt_reg <= pt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pt_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_rd)
            begin
                busy_reg <= 1'b1;
            end
            else if (step && pt_next.last)
            begin
                busy_reg <= 1'b0;
            end
            if (step)
            begin
                pt_valid_reg <= 1'b1;
            end
            else if (pt_take)
            begin
                pt_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/hlli_map.sv
// ----------------------------------------------------------------------------
// hlli_map
// Maps a hex point to its serpentine LED index and holds the result item.
// ----------------------------------------------------------------------------
module hlli_map
#(
    parameter int RING_CNT = hlli_pkg::RING_CNT_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pt_valid,
    input  hlli_pkg::point_t                     pt,
    output logic                                 pt_take,
    input  logic                                 pop,
    output logic                                 empty,
    output logic        [hlli_pkg::IDX_W-1:0]    led_index,
    output logic                                 on_panel,
    output logic signed [hlli_pkg::COORD_W-1:0]  point_q,
    output logic signed [hlli_pkg::COORD_W-1:0]  point_r,
    output logic        [hlli_pkg::COLOR_W-1:0]  out_color,
    output logic                                 last_point
);
    import hlli_pkg::*;

    localparam logic signed [15:0] RS = 16'(RING_CNT);

    logic                      out_valid_reg;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      on_reg, on_next;
    logic signed [COORD_W-1:0] q_reg, r_reg;
    logic [COLOR_W-1:0]        color_reg;
    logic                      last_reg;
    logic signed [15:0]        q, r, s, row, qmin, col, len, base, m, idx;

    assign pt_take    = !out_valid_reg || pop;
    assign empty      = !out_valid_reg;
    assign led_index  = idx_reg;
    assign on_panel   = on_reg;
    assign point_q    = q_reg;
    assign point_r    = r_reg;
    assign out_color  = color_reg;
    assign last_point = last_reg;

    always_comb
    begin
        q    = 16'(pt.q);
        r    = 16'(pt.r);
        s    = -q - r;
        row  = r + RS - 16'sd1;
        qmin = (r < 0) ? (-(RS - 16'sd1) - r) : (-(RS - 16'sd1));
        col  = q - qmin;
        len  = 16'sd2 * RS - 16'sd1 - ((r < 0) ? -r : r);
        m    = r - 16'sd1;
        if (r <= 0)
        begin
            base = row * RS + ((row * (row - 16'sd1)) >>> 1);
        end
        else
        begin
            base = RS * RS + ((RS * (RS - 16'sd1)) >>> 1)
                 + m * (16'sd2 * RS - 16'sd2) - ((m * (m - 16'sd1)) >>> 1);
        end
        idx = row[0] ? (base + len - 16'sd1 - col) : (base + col);
        on_next = (q < RS) && (q > -RS) && (r < RS) && (r > -RS)
               && (s < RS) && (s > -RS);
        idx_next = on_next ? idx[IDX_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (pt_valid && pt_take)
        begin
            idx_reg   <= idx_next;
            on_reg    <= on_next;
            q_reg     <= pt.q[COORD_W-1:0];
            r_reg     <= pt.r[COORD_W-1:0];
            color_reg <= pt.color;
            last_reg  <= pt.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pt_take)
        begin
            out_valid_reg <= pt_valid;
        end
    end

endmodule

FILE: hw/rtl/hlli_checker.sv
// ----------------------------------------------------------------------------
// hlli_checker
// Port-level checks on the result side of the hex line walker.
// ----------------------------------------------------------------------------
module hlli_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 empty,
    input logic                                 pop,
    input logic        [hlli_pkg::IDX_W-1:0]    led_index,
    input logic                                 on_panel,
    input logic signed [hlli_pkg::COORD_W-1:0]  point_q,
    input logic signed [hlli_pkg::COORD_W-1:0]  point_r
);
    import hlli_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(led_index) && $stable(point_q)))
        else $error("result item changed while stalled");

    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !on_panel) |-> (led_index == '0))
        else $error("off-panel item has nonzero index");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (point_q != -5'sd16 && point_r != -5'sd16))
        else $error("point coordinate out of range");

endmodule

bind hex_line_led_indices hlli_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .led_index (led_index),
    .on_panel  (on_panel),
    .point_q   (point_q),
    .point_r   (point_r)
);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hex line LED walker: random and directed lines
// are pushed, every point is predicted in the bench and compared on pop.
// ----------------------------------------------------------------------------
class hex_point_board;

    typedef struct {
        logic [7:0]  idx;
        logic        on;
        logic [4:0]  q;
        logic [4:0]  r;
        logic [23:0] color;
        logic        last;
    } point_exp_t;

    point_exp_t pending[$];
    int         rings;
    int         errors;
    int         points;
    int         lines;

    function new(int rings_i);
        rings  = rings_i;
        errors = 0;
        points = 0;
        lines  = 0;
    endfunction

    function int sat5(logic [4:0] v);
        int x;
        x = $signed(v);
        if (x < -15)
        begin
            x = -15;
        end
        return x;
    endfunction

    function int mag(int x);
        return x < 0 ? -x : x;
    endfunction

    function int round_half_away(int n, int d);
        if (n >= 0)
        begin
            return (2 * n + d) / (2 * d);
        end
        return -((-2 * n + d) / (2 * d));
    endfunction

    function int row_width(int row);
        return 2 * rings - 1 - mag(row - (rings - 1));
    endfunction

    function void note_line(logic [4:0] sq, logic [4:0] sr, logic [4:0] eq,
                            logic [4:0] er, logic [23:0] color);
        int aq, ar, as_, dq, dr, ds, span, rq, rr, rs, nq, nr, ns, xq, xr, xs;
        int row, qmin, col, base;
        point_exp_t p;
        aq   = sat5(sq);
        ar   = sat5(sr);
        dq   = sat5(eq) - aq;
        dr   = sat5(er) - ar;
        as_  = -aq - ar;
        ds   = -dq - dr;
        span = (mag(dq) + mag(dr) + mag(ds)) / 2;
        lines++;
        for (int i = 0; i <= span; i++)
        begin
            rq = aq;
            rr = ar;
            if (span != 0)
            begin
                nq = aq * span + dq * i;
                nr = ar * span + dr * i;
                ns = as_ * span + ds * i;
                rq = round_half_away(nq, span);
                rr = round_half_away(nr, span);
                rs = round_half_away(ns, span);
                xq = mag(rq * span - nq);
                xr = mag(rr * span - nr);
                xs = mag(rs * span - ns);
                if (xq > xr && xq > xs)
                begin
                    rq = -rr - rs;
                end
                else if (xr > xs)
                begin
                    rr = -rq - rs;
                end
            end
            rs = -rq - rr;
            p.on  = mag(rq) < rings && mag(rr) < rings && mag(rs) < rings;
            p.idx = 0;
            if (p.on)
            begin
                row  = rr + rings - 1;
                qmin = -(rings - 1);
                if (-(rings - 1) - rr > qmin)
                begin
                    qmin = -(rings - 1) - rr;
                end
                col  = rq - qmin;
                base = 0;
                for (int k = 0; k < row; k++)
                begin
                    base += row_width(k);
                end
                if (row % 2 == 0)
                begin
                    p.idx = 8'(base + col);
                end
                else
                begin
                    p.idx = 8'(base + row_width(row) - 1 - col);
                end
            end
            p.q     = 5'(rq);
            p.r     = 5'(rr);
            p.color = color;
            p.last  = (i == span);
            pending = {pending, p};
        end
    endfunction

    function void report(string what, int got, int want);
        $display("mismatch point %0d: %s got %0d expected %0d", points, what, got, want);
        errors++;
    endfunction

    function void check_point(logic [7:0] idx, logic on, logic [4:0] q, logic [4:0] r,
                              logic [23:0] color, logic last);
        point_exp_t p;
        if (pending.size() == 0)
        begin
            report("unexpected item", 1, 0);
            return;
        end
        p = pending.pop_front();
        if (idx !== p.idx) report("led_index", idx, p.idx);
        if (on !== p.on) report("on_panel", on, p.on);
        if (q !== p.q) report("point_q", q, p.q);
        if (r !== p.r) report("point_r", r, p.r);
        if (color !== p.color) report("out_color", color, p.color);
        if (last !== p.last) report("last_point", last, p.last);
        points++;
    endfunction

endclass

module tb;

    import hlli_pkg::*;

    localparam int RINGS      = RING_CNT_DEF;
    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [4:0]  start_q;
    logic [4:0]  start_r;
    logic [4:0]  end_q;
    logic [4:0]  end_r;
    logic [23:0] pixel_color;
    logic        empty;
    logic        pop;
    logic [7:0]  led_index;
    logic        on_panel;
    logic [4:0]  point_q;
    logic [4:0]  point_r;
    logic [23:0] out_color;
    logic        last_point;

    hex_point_board board;
    int  idle_cycles;
    bit  calm;
    bit  hold_pop;
    int  hold_len;

    hex_line_led_indices #(.RING_CNT(RINGS)) uut
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .start_q(start_q), .start_r(start_r), .end_q(end_q), .end_r(end_r),
        .pixel_color(pixel_color), .empty(empty), .pop(pop),
        .led_index(led_index), .on_panel(on_panel), .point_q(point_q),
        .point_r(point_r), .out_color(out_color), .last_point(last_point)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // sample accepted items and watch for stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                board.note_line(start_q, start_r, end_q, end_r, pixel_color);
            end
            if (pop && !empty)
            begin
                board.check_point(led_index, on_panel, point_q, point_r, out_color,
                                  last_point);
            end
            if ((push && !full) || (pop && !empty) || (!push && board.pending.size() == 0))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, a steady pop when calm, or a long hold when asked
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_pop)
        begin
            pop <= 1'b0;
        end
        else if (calm)
        begin
            pop <= 1'b1;
        end
        else if (hold_len > 0)
        begin
            hold_len <= hold_len - 1;
            pop      <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            hold_len <= $urandom_range(1, 17) - 1;
            pop      <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    task automatic send_line(logic [4:0] sq, logic [4:0] sr, logic [4:0] eq,
                             logic [4:0] er, logic [23:0] color, bit gaps);
        int gap;
        if (gaps && !calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push        <= 1'b1;
        start_q     <= sq;
        start_r     <= sr;
        end_q       <= eq;
        end_r       <= er;
        pixel_color <= color;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain;
        push <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [4:0] rnd_coord(bit near);
        if (near)
        begin
            return 5'($signed($urandom_range(0, 14)) - 7);
        end
        return 5'($urandom);
    endfunction

    initial
    begin
        logic [4:0] sq, sr;
        board       = new(RINGS);
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        start_q     = '0;
        start_r     = '0;
        end_q       = '0;
        end_r       = '0;
        pixel_color = '0;
        idle_cycles = 0;
        calm        = 1'b0;
        hold_pop    = 1'b0;
        hold_len    = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero length, extremes, -16 saturation, off panel, ties
        send_line(5'd0, 5'd0, 5'd0, 5'd0, 24'h000000, 0);
        send_line(5'd15, 5'd0, 5'd15, 5'd0, 24'hFFFFFF, 0);
        send_line(5'd16, 5'd16, 5'd15, 5'd15, 24'hA5A5A5, 0);
        send_line(5'd15, 5'd16, 5'd17, 5'd15, 24'h5A5A5A, 0);
        send_line(5'd17, 5'd15, 5'd15, 5'd17, 24'h123456, 0);
        send_line(5'd0, 5'd0, 5'd7, 5'd0, 24'h0000FF, 0);
        send_line(5'd0, 5'd0, 5'd2, 5'd1, 24'h00FF00, 0);
        send_line(5'd25, 5'd7, 5'd7, 5'd25, 24'hFF0000, 0);
        send_line(5'd1, 5'd0, 5'd0, 5'd1, 24'h800001, 0);
        send_line(5'd0, 5'd25, 5'd0, 5'd7, 24'h7FFFFE, 0);
        send_line(5'd31, 5'd0, 5'd1, 5'd1, 24'hC0FFEE, 0);
        send_line(5'd16, 5'd0, 5'd15, 5'd0, 24'h010203, 0);
        drain();

        // fill the block while the receiver holds off
        hold_pop = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_pop = 1'b0;
            end
            for (int n = 0; n < 8; n++)
            begin
                send_line(rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1),
                          24'($urandom), 0);
            end
        join
        drain();

        for (int n = 0; n < 190; n++)
        begin
            if (n == 150)
            begin
                calm = 1'b1;
            end
            if (n == 80)
            begin
                drain();
            end
            if ($urandom_range(0, 3) == 0)
            begin
                sq = rnd_coord(1);
                sr = rnd_coord(1);
                send_line(sq, sr, sq, sr, 24'($urandom), 1);
            end
            else
            begin
                bit near;
                near = $urandom_range(0, 2) != 0;
                send_line(rnd_coord(near), rnd_coord(near), rnd_coord(near),
                          rnd_coord(near), 24'($urandom), 1);
            end
        end
        drain();
        repeat (20) @(negedge clk);

        $display("covered %0d lines and %0d points, with stalls on both sides",
                 board.lines, board.points);
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: hex_line_led_indices.f
hw/rtl/hlli_pkg.sv
hw/rtl/hlli_front.sv
hw/rtl/hlli_queue.sv
hw/rtl/hlli_walk.sv
hw/rtl/hlli_map.sv
hw/rtl/hex_line_led_indices.sv
hw/rtl/hlli_checker.sv
dv/tb.sv
